// ----- rtl/core/rkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// rkvc_pkg
// Shared types and constants for the rotary knob value controller: register
// map, button event and LED codes, and the bundles passed between modules.
// ----------------------------------------------------------------------------
package rkvc_pkg;

  // Configuration port geometry: six 32-bit registers at 4-byte spacing.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (paddr[4:2]).
  localparam logic [2:0] REG_MIN_VALUE     = 3'd0;
  localparam logic [2:0] REG_MAX_VALUE     = 3'd1;
  localparam logic [2:0] REG_SMALL_STEP    = 3'd2;
  localparam logic [2:0] REG_LARGE_STEP    = 3'd3;
  localparam logic [2:0] REG_HOLD_TIME     = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE_TIME = 3'd5;

  // Reset values of the registers.
  localparam logic signed [15:0] MIN_VALUE_RST     = 16'sd0;
  localparam logic signed [15:0] MAX_VALUE_RST     = 16'sd127;
  localparam logic [11:0]        SMALL_STEP_RST    = 12'd1;
  localparam logic [11:0]        LARGE_STEP_RST    = 12'd10;
  localparam logic [15:0]        HOLD_TIME_RST     = 16'd1000;
  localparam logic [15:0]        DEBOUNCE_TIME_RST = 16'd5;

  // Button events reported with each result.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } btn_evt_e;

  // Indicator LED colors.
  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_WHITE = 2'd1,
    LED_RED   = 2'd2,
    LED_GREEN = 2'd3
  } led_e;

  // Configuration register bundle.
  typedef struct packed {
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic [11:0]        small_step;
    logic [11:0]        large_step;
    logic [15:0]        hold_time;
    logic [15:0]        debounce_time;
  } cfg_t;

  // Button status for the current poll.
  typedef struct packed {
    logic     down;    // button state after the button update
    logic     active;  // button was down at poll start or pressed now
    btn_evt_e evt;
    led_e     led;     // final LED color, turn override included
  } btn_status_t;

endpackage

// ----- rtl/core/rkvc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rkvc_cfg_regs
// APB-style configuration registers: write decode, read mux and storage of
// the range, step and timing settings.
// ----------------------------------------------------------------------------
module rkvc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rkvc_pkg::ADDR_W-1:0] paddr,
  input  logic [rkvc_pkg::DATA_W-1:0] pwdata,
  output logic [rkvc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rkvc_pkg::cfg_t              cfg_o
);

  rkvc_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value     <= rkvc_pkg::MIN_VALUE_RST;
      cfg_q.max_value     <= rkvc_pkg::MAX_VALUE_RST;
      cfg_q.small_step    <= rkvc_pkg::SMALL_STEP_RST;
      cfg_q.large_step    <= rkvc_pkg::LARGE_STEP_RST;
      cfg_q.hold_time     <= rkvc_pkg::HOLD_TIME_RST;
      cfg_q.debounce_time <= rkvc_pkg::DEBOUNCE_TIME_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        rkvc_pkg::REG_MIN_VALUE:     cfg_q.min_value     <= signed'(pwdata[15:0]);
        rkvc_pkg::REG_MAX_VALUE:     cfg_q.max_value     <= signed'(pwdata[15:0]);
        rkvc_pkg::REG_SMALL_STEP:    cfg_q.small_step    <= pwdata[11:0];
        rkvc_pkg::REG_LARGE_STEP:    cfg_q.large_step    <= pwdata[11:0];
        rkvc_pkg::REG_HOLD_TIME:     cfg_q.hold_time     <= pwdata[15:0];
        rkvc_pkg::REG_DEBOUNCE_TIME: cfg_q.debounce_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux; signed registers read back sign extended.
  always_comb begin
    unique case (reg_idx)
      rkvc_pkg::REG_MIN_VALUE:     prdata = {{16{cfg_q.min_value[15]}}, cfg_q.min_value};
      rkvc_pkg::REG_MAX_VALUE:     prdata = {{16{cfg_q.max_value[15]}}, cfg_q.max_value};
      rkvc_pkg::REG_SMALL_STEP:    prdata = {20'd0, cfg_q.small_step};
      rkvc_pkg::REG_LARGE_STEP:    prdata = {20'd0, cfg_q.large_step};
      rkvc_pkg::REG_HOLD_TIME:     prdata = {16'd0, cfg_q.hold_time};
      rkvc_pkg::REG_DEBOUNCE_TIME: prdata = {16'd0, cfg_q.debounce_time};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/rkvc_button.sv -----
// ----------------------------------------------------------------------------
// rkvc_button
// Push button tracker: press, hold and release events, press timestamp and
// LED color. A committed turn while pressed suppresses the hold and turns
// the LED green.
// ----------------------------------------------------------------------------
module rkvc_button #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,         // request processed this cycle
  input  logic [TIME_BITS-1:0]    now_i,
  input  logic                    sw_i,
  input  logic [15:0]             hold_time_i,
  input  logic                    turn_grab_i,  // committed turn while pressed
  output rkvc_pkg::btn_status_t   status_o
);

  logic                 down_q, down_d;
  logic                 hold_q, hold_d, hold_n;
  logic [TIME_BITS-1:0] press_q, press_d;
  rkvc_pkg::led_e       led_q, led_d, led_n;
  rkvc_pkg::btn_evt_e   evt;
  logic                 active;
  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_due;

  // Time since the press, modulo the timer width.
  assign elapsed  = now_i - press_q;
  assign hold_due = elapsed > TIME_BITS'(hold_time_i);

  // Button event logic.
  always_comb begin
    down_d = down_q;
    press_d = press_q;
    hold_n = hold_q;
    led_n = led_q;
    evt = rkvc_pkg::EV_NONE;
    active = 1'b0;
    if (down_q) begin
      active = 1'b1;
      if (sw_i) begin
        if (hold_due && !hold_q) begin
          hold_n = 1'b1;
          led_n = rkvc_pkg::LED_RED;
          evt = rkvc_pkg::EV_HOLD;
        end
      end else begin
        down_d = 1'b0;
        hold_n = 1'b0;
        led_n = rkvc_pkg::LED_OFF;
        evt = rkvc_pkg::EV_RELEASE;
      end
    end else if (sw_i) begin
      down_d = 1'b1;
      press_d = now_i;
      hold_n = 1'b0;
      led_n = rkvc_pkg::LED_WHITE;
      evt = rkvc_pkg::EV_PRESS;
      active = 1'b1;
    end
  end

  // A turn during the press takes over the hold and the LED.
  assign hold_d = turn_grab_i ? 1'b1 : hold_n;
  assign led_d  = turn_grab_i ? rkvc_pkg::LED_GREEN : led_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= 1'b0;
      hold_q  <= 1'b0;
      press_q <= '0;
      led_q   <= rkvc_pkg::LED_OFF;
    end else if (en_i) begin
      down_q  <= down_d;
      hold_q  <= hold_d;
      press_q <= press_d;
      led_q   <= led_d;
    end
  end

  assign status_o.down   = down_d;
  assign status_o.active = active;
  assign status_o.evt    = evt;
  assign status_o.led    = led_d;

endmodule

// ----- rtl/core/rkvc_turn.sv -----
// ----------------------------------------------------------------------------
// rkvc_turn
// Encoder count accumulator and knob value: debounces the count, converts it
// to detents, scales by the selected step and clamps to the allowed range.
// ----------------------------------------------------------------------------
module rkvc_turn #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,        // request processed this cycle
  input  logic [TIME_BITS-1:0]     now_i,
  input  logic signed [1:0]        quad_step_i,
  input  logic                     btn_down_i,  // button state after update
  input  rkvc_pkg::cfg_t           cfg_i,
  output logic                     grab_o,      // committed turn while pressed
  output logic                     changed_o,
  output logic signed [15:0]       value_o
);

  logic signed [15:0]   value_q, value_d;
  logic signed [15:0]   count_q, count_d;
  logic                 pending_q, pending_d;
  logic [TIME_BITS-1:0] start_q, start_d;

  logic signed [15:0]   count_sum;
  logic [TIME_BITS-1:0] elapsed;
  logic                 still_due;
  logic                 check;
  logic                 pos_turn, neg_turn, commit;
  logic [16:0]          pos_round, neg_round, neg_mag;
  logic [14:0]          detents;
  logic signed [15:0]   det;
  logic [11:0]          inc;
  logic signed [28:0]   prod;
  logic signed [29:0]   sum;
  logic signed [29:0]   lo_clamped, clamped;
  logic signed [15:0]   new_value;

  // Accumulate and debounce the raw count.
  assign count_sum = count_q + {{14{quad_step_i[1]}}, quad_step_i};
  assign elapsed   = now_i - start_q;
  assign still_due = elapsed > TIME_BITS'(cfg_i.debounce_time);
  assign check     = (quad_step_i == 2'sd0) && pending_q && still_due;

  // Detents: count over four, rounded away from zero.
  assign pos_turn  = count_q > 16'sd2;
  assign neg_turn  = count_q < -16'sd2;
  assign commit    = check && (pos_turn || neg_turn);
  assign pos_round = {1'b0, count_q} + 17'd3;
  assign neg_mag   = 17'd0 - {count_q[15], count_q};
  assign neg_round = neg_mag + 17'd3;
  assign detents   = neg_turn ? neg_round[16:2] : pos_round[16:2];
  assign det       = neg_turn ? -signed'({1'b0, detents}) : signed'({1'b0, detents});

  // Scale by the step and clamp; the max bound is applied last.
  assign inc  = btn_down_i ? cfg_i.large_step : cfg_i.small_step;
  assign prod = 29'(signed'({1'b0, inc})) * 29'(det);
  assign sum  = 30'(value_q) + 30'(prod);

  always_comb begin
    lo_clamped = (sum < 30'(cfg_i.min_value)) ? 30'(cfg_i.min_value) : sum;
    clamped    = (lo_clamped > 30'(cfg_i.max_value)) ? 30'(cfg_i.max_value) : lo_clamped;
  end

  assign new_value = clamped[15:0];
  assign changed_o = commit && (new_value != value_q);
  assign grab_o    = commit && btn_down_i;
  assign value_d   = changed_o ? new_value : value_q;
  assign value_o   = value_d;

  // Next state of the count tracker.
  always_comb begin
    count_d   = count_q;
    pending_d = pending_q;
    start_d   = start_q;
    if (quad_step_i != 2'sd0) begin
      count_d = count_sum;
      if (!pending_q) begin
        pending_d = 1'b1;
        start_d   = now_i;
      end
    end else if (check) begin
      pending_d = 1'b0;
      if (commit) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q   <= '0;
      count_q   <= '0;
      pending_q <= 1'b0;
      start_q   <= '0;
    end else if (en_i) begin
      value_q   <= value_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      start_q   <= start_d;
    end
  end

endmodule

// ----- rtl/core/rotary_knob_value_controller.sv -----
// ----------------------------------------------------------------------------
// rotary_knob_value_controller
// Rotary encoder knob with push button: turns into a clamped value, button
// events and an indicator LED color, one result per poll.
// ----------------------------------------------------------------------------
// Usage:
//   Each poll request on the input channel (time_ms_i, quad_step_i,
//   switch_level_i) produces exactly one result request on the output
//   channel (knob_value_o, value_changed_o, button_event_o, led_colour_o,
//   activity_o). Both channels use valid and stall; a request moves at a
//   clock edge with valid high and stall low.
//   The poll is captured in an input register, then all button and turn
//   logic runs in one pass into the result register.
//   Throughput is one poll per clock while the receiver does not stall;
//   the path through the step multiply, add and clamp sets the cycle time.
//   When the receiver stalls, the result is held. An empty input register
//   still takes one more poll; once it is full, in_stall_o rises in the
//   same cycle as out_stall_i.
//   Reset clears the knob value, the turn and button state and sets the
//   registers to their defaults. The user must write the registers through
//   the APB port only while no poll is in flight; no logic enforces it.
// ----------------------------------------------------------------------------
module rotary_knob_value_controller #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Poll channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 time_ms_i,
  input  logic signed [1:0]           quad_step_i,
  input  logic                        switch_level_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          knob_value_o,
  output logic                        value_changed_o,
  output logic [1:0]                  button_event_o,
  output logic [1:0]                  led_colour_o,
  output logic [1:0]                  activity_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rkvc_pkg::ADDR_W-1:0] paddr,
  input  logic [rkvc_pkg::DATA_W-1:0] pwdata,
  output logic [rkvc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned EXT_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  rkvc_pkg::cfg_t        cfg;
  rkvc_pkg::btn_status_t btn;

  logic                  in_valid_q;
  logic [31:0]           time_q;
  logic signed [1:0]     step_q;
  logic                  sw_q;
  logic                  advance;
  logic                  work_en;
  logic [EXT_BITS-1:0]   time_ext;
  logic [TIME_BITS-1:0]  now;

  logic                  grab;
  logic                  changed;
  logic signed [15:0]    value;

  logic                  out_valid_q;
  logic signed [15:0]    value_q;
  logic                  changed_q;
  logic [1:0]            evt_q;
  logic [1:0]            led_q;
  logic [1:0]            activity_q;

  // Handshake: the input register moves on when the result slot is free.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign work_en    = in_valid_q && advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      time_q <= time_ms_i;
      step_q <= quad_step_i;
      sw_q   <= switch_level_i;
    end
  end

  // Timestamp reduced to the timer width.
  assign time_ext = EXT_BITS'(time_q);
  assign now      = time_ext[TIME_BITS-1:0];

  rkvc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rkvc_button #(
    .TIME_BITS (TIME_BITS)
  ) u_button (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (work_en),
    .now_i       (now),
    .sw_i        (sw_q),
    .hold_time_i (cfg.hold_time),
    .turn_grab_i (grab),
    .status_o    (btn)
  );

  rkvc_turn #(
    .TIME_BITS (TIME_BITS)
  ) u_turn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (work_en),
    .now_i       (now),
    .quad_step_i (step_q),
    .btn_down_i  (btn.down),
    .cfg_i       (cfg),
    .grab_o      (grab),
    .changed_o   (changed),
    .value_o     (value)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_en) begin
      value_q    <= value;
      changed_q  <= changed;
      evt_q      <= btn.evt;
      led_q      <= btn.led;
      activity_q <= {btn.active & changed, btn.active ^ changed};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign knob_value_o    = value_q;
  assign value_changed_o = changed_q;
  assign button_event_o  = evt_q;
  assign led_colour_o    = led_q;
  assign activity_o      = activity_q;

endmodule

// ----- rtl/core/rkvc_checker.sv -----
// ----------------------------------------------------------------------------
// rkvc_checker
// Port-level checks for the rotary knob value controller, bound to the top
// level.
// ----------------------------------------------------------------------------
module rkvc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [15:0]          knob_value_o,
  input logic                        value_changed_o,
  input logic [1:0]                  button_event_o,
  input logic [1:0]                  led_colour_o,
  input logic [1:0]                  activity_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(knob_value_o)
      && $stable(button_event_o) && $stable(led_colour_o))
    else $error("stalled result changed");

  // Activity is a sum of two flags and never reads three.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> activity_o != 2'd3)
    else $error("activity out of range");

  // A value change always counts toward activity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_changed_o |-> activity_o != 2'd0)
    else $error("value change without activity");

  // A release always leaves the LED off and counts toward activity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && button_event_o == rkvc_pkg::EV_RELEASE
      |-> led_colour_o == rkvc_pkg::LED_OFF && activity_o != 2'd0)
    else $error("release with LED lit");

  // A press lights the LED white, or green when a turn commits at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && button_event_o == rkvc_pkg::EV_PRESS
      |-> led_colour_o == rkvc_pkg::LED_WHITE || led_colour_o == rkvc_pkg::LED_GREEN)
    else $error("press with wrong LED color");

endmodule

bind rotary_knob_value_controller rkvc_checker u_rkvc_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotary knob value controller. A short table of
// polls covers turn commits, small turns, press, hold, release and time
// wrap-around. Random polls, made mostly of turn bursts and press sequences,
// then run under several register settings. Every result is checked against
// a cycle-free predictor or, for typed table rows, against the typed result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One result as seen on the output channel.
  typedef struct packed {
    logic signed [15:0]  knob;
    logic                changed;
    rkvc_pkg::btn_evt_e  evt;
    rkvc_pkg::led_e      led;
    logic [1:0]          activity;
  } knob_result_t;

  // One row of the directed table: a poll and, where typed, its result.
  typedef struct packed {
    logic [31:0]        t;
    logic signed [1:0]  q;
    logic               sw;
    logic               typed;
    knob_result_t       res;
  } poll_row_t;

  localparam logic signed [1:0] STEP_NONE        = 2'sb00;
  localparam logic signed [1:0] STEP_UP          = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN        = 2'sb11;
  localparam logic signed [1:0] STEP_DOUBLE_DOWN = 2'sb10;

  localparam int IDLE_PERCENT     = 22;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int CALM_FROM        = 700;
  localparam int CALM_TO          = 900;
  localparam int BACKLOG_AT       = 300;
  localparam int BACKLOG_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int MAX_REPORTS      = 10;

  localparam knob_result_t IDLE_RESULT =
    '{16'sd0, 1'b0, rkvc_pkg::EV_NONE, rkvc_pkg::LED_OFF, 2'd0};

  // Directed polls, run with the reset register values.
  localparam int NUM_DIRECTED = 26;
  localparam poll_row_t DIRECTED_POLLS [NUM_DIRECTED] = '{
    // First poll after reset, then a turn that is not committed yet.
    '{32'd0,          STEP_NONE,        1'b0, 1'b1, IDLE_RESULT},
    '{32'd1,          STEP_UP,          1'b0, 1'b1, IDLE_RESULT},
    '{32'd2,          STEP_UP,          1'b0, 1'b0, '0},
    // Still for exactly the debounce time, then one more: a small turn.
    '{32'd6,          STEP_NONE,        1'b0, 1'b0, '0},
    '{32'd7,          STEP_NONE,        1'b0, 1'b0, '0},
    // The kept count grows to three and commits one detent up.
    '{32'd8,          STEP_UP,          1'b0, 1'b0, '0},
    '{32'd20,         STEP_NONE,        1'b0, 1'b0, '0},
    // The double-step pattern counts as minus two.
    '{32'd21,         STEP_DOUBLE_DOWN, 1'b0, 1'b0, '0},
    '{32'd22,         STEP_DOWN,        1'b0, 1'b0, '0},
    '{32'd30,         STEP_NONE,        1'b0, 1'b0, '0},
    // Press, hold only once past the hold time, no second hold, release.
    '{32'd100,        STEP_NONE,        1'b1, 1'b1,
      '{16'sd0, 1'b0, rkvc_pkg::EV_PRESS, rkvc_pkg::LED_WHITE, 2'd1}},
    '{32'd1100,       STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd1101,       STEP_NONE,        1'b1, 1'b1,
      '{16'sd0, 1'b0, rkvc_pkg::EV_HOLD, rkvc_pkg::LED_RED, 2'd1}},
    '{32'd5000,       STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd5001,       STEP_NONE,        1'b0, 1'b1,
      '{16'sd0, 1'b0, rkvc_pkg::EV_RELEASE, rkvc_pkg::LED_OFF, 2'd1}},
    // A turn while pressed uses the large step, goes green, blocks the hold.
    '{32'd5002,       STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd5003,       STEP_UP,          1'b1, 1'b0, '0},
    '{32'd5004,       STEP_UP,          1'b1, 1'b0, '0},
    '{32'd5005,       STEP_UP,          1'b1, 1'b0, '0},
    '{32'd5020,       STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd7000,       STEP_NONE,        1'b1, 1'b0, '0},
    // Press at the top of the time range; the hold time spans the wrap.
    '{32'hFFFF_FFF0,  STEP_NONE,        1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF,  STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd1000,       STEP_NONE,        1'b1, 1'b0, '0},
    '{32'd1001,       STEP_DOWN,        1'b0, 1'b0, '0},
    '{32'd1010,       STEP_NONE,        1'b0, 1'b0, '0}
  };

  // Register settings of the later phases; the last phase draws its own.
  localparam int NUM_FIXED_PHASES = 4;
  localparam int PHASE_SETTINGS [NUM_FIXED_PHASES][6] = '{
    '{-100,   100,   3,    50,   20,    3},
    '{-32768, 32767, 4095, 4095, 0,     0},
    '{0,      0,     0,    0,    65535, 65535},
    '{50,     -50,   7,    1,    10,    2}
  };

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [31:0]                         time_ms_i = '0;
  logic signed [1:0]                   quad_step_i = '0;
  logic                                switch_level_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [15:0]                  knob_value_o;
  logic                                value_changed_o;
  logic [1:0]                          button_event_o;
  logic [1:0]                          led_colour_o;
  logic [1:0]                          activity_o;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [rkvc_pkg::ADDR_W-1:0]         paddr = '0;
  logic [rkvc_pkg::DATA_W-1:0]         pwdata = '0;
  logic [rkvc_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  // Predictor copy of the registers.
  int          lim_lo = int'(rkvc_pkg::MIN_VALUE_RST);
  int          lim_hi = int'(rkvc_pkg::MAX_VALUE_RST);
  int          step_fine = int'(rkvc_pkg::SMALL_STEP_RST);
  int          step_coarse = int'(rkvc_pkg::LARGE_STEP_RST);
  logic [31:0] hold_ms = {16'd0, rkvc_pkg::HOLD_TIME_RST};
  logic [31:0] settle_ms = {16'd0, rkvc_pkg::DEBOUNCE_TIME_RST};

  // Predictor copy of the knob state.
  logic signed [15:0] knob_val = '0;
  logic signed [15:0] spin_count = '0;
  logic               turn_armed = 1'b0;
  logic [31:0]        turn_t0 = '0;
  logic               btn_held = 1'b0;
  logic [31:0]        press_t0 = '0;
  logic               hold_fired = 1'b0;
  rkvc_pkg::led_e     led_now = rkvc_pkg::LED_OFF;

  knob_result_t expected_results [$];

  int          polls_sent = 0;
  int          random_polls = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          holds_seen = 0;
  int          changes_seen = 0;
  int          idle_cycles = 0;
  int          stall_hold_left = 0;
  logic        backlog_done = 1'b0;
  logic        random_part = 1'b0;
  logic [31:0] now_ms = '0;
  logic        quiet_stretch;

  assign quiet_stretch = (random_polls >= CALM_FROM) && (random_polls < CALM_TO);

  rotary_knob_value_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .time_ms_i      (time_ms_i),
    .quad_step_i    (quad_step_i),
    .switch_level_i (switch_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .knob_value_o   (knob_value_o),
    .value_changed_o(value_changed_o),
    .button_event_o (button_event_o),
    .led_colour_o   (led_colour_o),
    .activity_o     (activity_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the predicted knob by one poll and return the result it gives.
  function automatic knob_result_t predict_poll(input logic [31:0] t,
                                                input logic signed [1:0] q,
                                                input logic sw);
    knob_result_t r;
    logic         active;
    logic         changed;
    logic [31:0]  held_for;
    logic [31:0]  still_for;
    int           delta;
    int           detents;
    int           incr;
    int           v;
    r = IDLE_RESULT;
    active = 1'b0;
    changed = 1'b0;
    held_for = t - press_t0;
    still_for = t - turn_t0;

    // The button is handled before the turn.
    if (btn_held) begin
      if (sw) begin
        if (held_for > hold_ms && !hold_fired) begin
          hold_fired = 1'b1;
          led_now = rkvc_pkg::LED_RED;
          r.evt = rkvc_pkg::EV_HOLD;
        end
      end else begin
        btn_held = 1'b0;
        hold_fired = 1'b0;
        led_now = rkvc_pkg::LED_OFF;
        r.evt = rkvc_pkg::EV_RELEASE;
      end
      active = 1'b1;
    end else if (sw) begin
      btn_held = 1'b1;
      press_t0 = t;
      hold_fired = 1'b0;
      led_now = rkvc_pkg::LED_WHITE;
      r.evt = rkvc_pkg::EV_PRESS;
      active = 1'b1;
    end

    // Accumulate the count; commit whole detents once it has been still.
    if (q != STEP_NONE) begin
      spin_count = spin_count + q;
      if (!turn_armed) begin
        turn_armed = 1'b1;
        turn_t0 = t;
      end
    end else if (turn_armed && still_for > settle_ms) begin
      turn_armed = 1'b0;
      delta = int'(spin_count);
      if (delta > 2 || delta < -2) begin
        detents = (delta > 2) ? (delta + 3) / 4 : -((3 - delta) / 4);
        incr = btn_held ? step_coarse : step_fine;
        v = int'(knob_val) + incr * detents;
        spin_count = '0;
        if (btn_held) begin
          hold_fired = 1'b1;
          led_now = rkvc_pkg::LED_GREEN;
        end
        if (v < lim_lo) v = lim_lo;
        if (v > lim_hi) v = lim_hi;
        if (v != int'(knob_val)) begin
          knob_val = 16'(v);
          changed = 1'b1;
        end
      end
    end

    r.knob = knob_val;
    r.changed = changed;
    r.led = led_now;
    r.activity = {1'b0, active} + {1'b0, changed};
    return r;
  endfunction

  // Offer one poll request, hold it until it is taken, then predict it.
  task automatic send_poll(input logic [31:0] t, input logic signed [1:0] q,
                           input logic sw, input logic typed = 1'b0,
                           input knob_result_t typed_res = '0);
    knob_result_t pred;
    while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_ms_i <= t;
    quad_step_i <= q;
    switch_level_i <= sw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_poll(t, q, sw);
    expected_results.push_back(typed ? typed_res : pred);
    polls_sent++;
    if (random_part) random_polls++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      rkvc_pkg::REG_MIN_VALUE:     lim_lo = int'($signed(data[15:0]));
      rkvc_pkg::REG_MAX_VALUE:     lim_hi = int'($signed(data[15:0]));
      rkvc_pkg::REG_SMALL_STEP:    step_fine = int'(data[11:0]);
      rkvc_pkg::REG_LARGE_STEP:    step_coarse = int'(data[11:0]);
      rkvc_pkg::REG_HOLD_TIME:     hold_ms = {16'd0, data[15:0]};
      rkvc_pkg::REG_DEBOUNCE_TIME: settle_ms = {16'd0, data[15:0]};
      default: ;
    endcase
  endtask

  task automatic load_config(input int lo, input int hi, input int fine_step,
                             input int coarse_step, input int hold, input int settle);
    write_reg(rkvc_pkg::REG_MIN_VALUE, {16'd0, 16'(lo)});
    write_reg(rkvc_pkg::REG_MAX_VALUE, {16'd0, 16'(hi)});
    write_reg(rkvc_pkg::REG_SMALL_STEP, {20'd0, 12'(fine_step)});
    write_reg(rkvc_pkg::REG_LARGE_STEP, {20'd0, 12'(coarse_step)});
    write_reg(rkvc_pkg::REG_HOLD_TIME, {16'd0, 16'(hold)});
    write_reg(rkvc_pkg::REG_DEBOUNCE_TIME, {16'd0, 16'(settle)});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A nonzero count step in the given direction.
  function automatic logic signed [1:0] turn_step(input logic up);
    if (up) return STEP_UP;
    return ($urandom_range(7) == 0) ? STEP_DOUBLE_DOWN : STEP_DOWN;
  endfunction

  // Random polls: turn bursts that settle, press sequences, quiet polls, noise.
  task automatic run_random(input int count);
    int   stop_at;
    int   kind;
    int   len;
    logic up;
    stop_at = random_polls + count;
    while (random_polls < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // Turn burst, some still polls, then one that is surely settled.
        len = $urandom_range(1, 12);
        up = 1'($urandom_range(1));
        repeat (len) begin
          now_ms += $urandom_range(settle_ms / 2);
          send_poll(now_ms, turn_step(($urandom_range(9) == 0) ? !up : up), 1'b0);
        end
        repeat ($urandom_range(1, 3)) begin
          now_ms += $urandom_range(settle_ms + 2);
          send_poll(now_ms, STEP_NONE, 1'b0);
        end
        now_ms += settle_ms + 1 + $urandom_range(3);
        send_poll(now_ms, STEP_NONE, 1'b0);
      end else if (kind < 70) begin
        // Press sequence, with turns and holds inside, then a release.
        len = $urandom_range(1, 8);
        repeat (len) begin
          now_ms += $urandom_range(hold_ms / 2 + 2);
          if ($urandom_range(2) == 0) begin
            send_poll(now_ms, turn_step(1'($urandom_range(1))), 1'b1);
          end else begin
            send_poll(now_ms, STEP_NONE, 1'b1);
          end
        end
        now_ms += $urandom_range(settle_ms + 2);
        send_poll(now_ms, STEP_NONE, 1'b0);
      end else if (kind < 90) begin
        now_ms += $urandom_range(settle_ms * 2 + 2);
        send_poll(now_ms, STEP_NONE, 1'b0);
      end else begin
        now_ms = $urandom();
        send_poll(now_ms, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off, and a stretch with none.
  always @(posedge clk_i) begin
    if (stall_hold_left > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_left <= stall_hold_left - 1;
    end else if (!backlog_done && random_polls >= BACKLOG_AT) begin
      out_stall_i <= 1'b1;
      stall_hold_left <= BACKLOG_CYCLES;
      backlog_done <= 1'b1;
    end else if (quiet_stretch) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    knob_result_t got;
    knob_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.knob = knob_value_o;
      got.changed = value_changed_o;
      got.evt = rkvc_pkg::btn_evt_e'(button_event_o);
      got.led = rkvc_pkg::led_e'(led_colour_o);
      got.activity = activity_o;
      results_seen++;
      if (got.evt == rkvc_pkg::EV_HOLD) holds_seen++;
      if (got.changed) changes_seen++;
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("[%0t] result with nothing expected: value %0d", $realtime,
                   $signed(got.knob));
        end
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("[%0t] result %0d differs", $realtime, results_seen);
            $display("  expected: value %0d changed %0b event %s led %s activity %0d",
                     $signed(want.knob), want.changed, want.evt.name(), want.led.name(),
                     want.activity);
            $display("  actual:   value %0d changed %0b event %s led %s activity %0d",
                     $signed(got.knob), got.changed, got.evt.name(), got.led.name(),
                     got.activity);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed polls with the reset register values.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_poll(DIRECTED_POLLS[i].t, DIRECTED_POLLS[i].q, DIRECTED_POLLS[i].sw,
                DIRECTED_POLLS[i].typed, DIRECTED_POLLS[i].res);
    end

    now_ms = 32'd2000;
    random_part = 1'b1;
    run_random(RANDOM_PER_PHASE);

    // Further phases: drain, load new registers, run random polls again.
    for (ph = 0; ph <= NUM_FIXED_PHASES; ph++) begin
      wait_idle();
      if (ph < NUM_FIXED_PHASES) begin
        load_config(PHASE_SETTINGS[ph][0], PHASE_SETTINGS[ph][1], PHASE_SETTINGS[ph][2],
                    PHASE_SETTINGS[ph][3], PHASE_SETTINGS[ph][4], PHASE_SETTINGS[ph][5]);
      end else begin
        load_config(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                    $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
                    $urandom_range(200));
      end
      // One phase starts just below the top of the time range to cross the wrap.
      now_ms = (ph == 1) ? 32'hFFFF_FF00 : $urandom();
      run_random(RANDOM_PER_PHASE);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d polls and %0d checked results under %0d register settings.",
             polls_sent, results_seen, NUM_FIXED_PHASES + 2);
    $display("Seen: %0d value changes, %0d hold events, %0d mismatches.",
             changes_seen, holds_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rkvc_pkg.sv
rtl/core/rkvc_cfg_regs.sv
rtl/core/rkvc_button.sv
rtl/core/rkvc_turn.sv
rtl/core/rotary_knob_value_controller.sv
rtl/core/rkvc_checker.sv
test/testbench.sv
